// ===== design/hlf_pkg.sv =====
package hlf_pkg;

    localparam int CELLS_DEFAULT = 16;

    localparam int WEIGHT_W = 16;
    localparam int QUO_W    = 17;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_COLOURS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_WEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_WEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXACT_WEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OVER_WEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNDER_WEIGHT  = 3'd5;

    localparam logic [WEIGHT_W-1:0] WORLD_COLOURS_RST = 16'd6;
    localparam logic [WEIGHT_W-1:0] HIT_WEIGHT_RST    = 16'd39322;
    localparam logic [WEIGHT_W-1:0] MISS_WEIGHT_RST   = 16'd13107;
    localparam logic [WEIGHT_W-1:0] EXACT_WEIGHT_RST  = 16'd52429;
    localparam logic [WEIGHT_W-1:0] OVER_WEIGHT_RST   = 16'd6554;
    localparam logic [WEIGHT_W-1:0] UNDER_WEIGHT_RST  = 16'd6554;

    localparam logic OP_SENSE = 1'b0;
    localparam logic OP_MOVE  = 1'b1;

    // convolution taps, in the order they are visited
    localparam logic [1:0] TAP_OVER  = 2'd0;
    localparam logic [1:0] TAP_EXACT = 2'd1;
    localparam logic [1:0] TAP_UNDER = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_MUL,
        S_SUM_ACC,
        S_DIV_RD,
        S_DIV_MUL,
        S_DIV_START,
        S_DIV_RUN,
        S_MV_RD,
        S_MV_MUL,
        S_MV_ACC,
        S_MV_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

endpackage

// ===== design/hlf_divider.sv =====
module hlf_divider #(
    parameter int SUM_W = 36
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [SUM_W+hlf_pkg::QUO_W-1:0] dividend,
    input  logic [SUM_W-1:0]              divisor,
    output logic                          done,
    output logic [hlf_pkg::QUO_W-1:0]     quotient
);

    localparam int QW = hlf_pkg::QUO_W;
    localparam int CNT_W = $clog2(QW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] div_reg;
    logic [QW-1:0]    low_reg;
    logic [QW-1:0]    quo_reg;

    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;
    logic             fits;
    logic             cnt_last;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, low_reg[QW-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = trial >= {1'b0, div_reg};
        cnt_last = cnt_reg == CNT_W'(QW - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // the top bits are already below the divisor
            rem_reg <= dividend[SUM_W+QW-1:QW];
            low_reg <= dividend[QW-1:0];
            div_reg <= divisor;
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            low_reg <= {low_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], fits};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_last && !start |=> done_reg && !busy_reg)
        else $error("divider did not finish after the last bit");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < div_reg)
        else $error("partial remainder not below divisor");

endmodule

// ===== design/histogram_localization_filter.sv =====
// sense request: a sum pass (read, multiply, accumulate per cell), a normalize pass on
// the bit-serial divider, then an output pass (read, load, wait for m_tready per cell)
// move request: 3 taps/cell through one shared 16x16 multiplier, then the output pass
// sense with zero sum: no normalize pass; one request at a time, s_tready low meanwhile
// reset: synchronous active-low aresetn; registers return to their defaults and the
// belief reads as uniform (65536 / CELLS) through per-cell valid bits, no clearing pass
module histogram_localization_filter #(
    parameter int CELLS = hlf_pkg::CELLS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [hlf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hlf_pkg::WEIGHT_W-1:0]    cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // seen_colour, shift[3:0], pad
    input  logic                            s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // cell_index[3:0], probability[15:0], pad
    output logic                            m_tuser,   // zero_sum
    output logic                            m_tlast
);

    localparam int IW        = $clog2(CELLS);
    localparam int TW        = IW + 2;
    localparam int SUM_W     = 32 + IW;
    localparam int ACC_W     = SUM_W + 2;
    localparam int DIV_W     = SUM_W + hlf_pkg::QUO_W;
    localparam int MEM_DEPTH = 1 << (IW + 1);
    localparam logic [15:0] BeliefInit = 16'(65536 / CELLS);

    hlf_pkg::state_t state_reg, state_next;

    logic [15:0] colours_reg, hit_reg, miss_reg, exact_reg, over_reg, under_reg;

    logic          seen_reg, seen_next;
    logic [IW-1:0] u_reg, u_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0]    tap_reg, tap_next;
    logic          bank_reg, bank_next;
    logic [CELLS-1:0] valid_reg, valid_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [31:0]   prod_reg, prod_next;
    logic          zero_reg, zero_next;
    logic [3:0]    out_idx_reg, out_idx_next;
    logic [15:0]   out_prob_reg, out_prob_next;
    logic          out_zero_reg, out_zero_next;
    logic          out_last_reg, out_last_next;

    logic [15:0]   belief_mem [MEM_DEPTH];
    logic [15:0]   rd_data_reg;
    logic          rd_valid_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW:0]   mem_waddr;
    logic [15:0]   mem_wdata;

    logic          idx_last;
    logic [15:0]   b_val;
    logic [15:0]   mul_w;
    logic [31:0]   mul_out;
    logic [63:0]   wc_ext;
    logic          cell_red;
    logic [ACC_W-1:0] sum_new;
    logic [ACC_W-1:0] rnd;
    logic [15:0]   move_val;
    logic [IW-1:0] u_in;
    logic [6:0]    u_work;
    logic [TW-1:0] tap_x;
    logic [TW-1:0] tap_y;
    logic [IW-1:0] tap_addr;

    logic          div_start;
    logic          div_done;
    logic [DIV_W-1:0] div_dividend;
    logic [hlf_pkg::QUO_W-1:0] div_quo;
    logic [15:0]   div_val;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colours_reg <= hlf_pkg::WORLD_COLOURS_RST;
            hit_reg     <= hlf_pkg::HIT_WEIGHT_RST;
            miss_reg    <= hlf_pkg::MISS_WEIGHT_RST;
            exact_reg   <= hlf_pkg::EXACT_WEIGHT_RST;
            over_reg    <= hlf_pkg::OVER_WEIGHT_RST;
            under_reg   <= hlf_pkg::UNDER_WEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                hlf_pkg::REG_WORLD_COLOURS: colours_reg <= cfg_wdata;
                hlf_pkg::REG_HIT_WEIGHT:    hit_reg     <= cfg_wdata;
                hlf_pkg::REG_MISS_WEIGHT:   miss_reg    <= cfg_wdata;
                hlf_pkg::REG_EXACT_WEIGHT:  exact_reg   <= cfg_wdata;
                hlf_pkg::REG_OVER_WEIGHT:   over_reg    <= cfg_wdata;
                hlf_pkg::REG_UNDER_WEIGHT:  under_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // shared arithmetic and address helpers
    always_comb begin
        idx_last = idx_reg == IW'(CELLS - 1);
        b_val    = rd_valid_reg ? rd_data_reg : BeliefInit;

        // cells beyond the colour register are green
        wc_ext   = 64'(colours_reg);
        cell_red = wc_ext[6'(idx_reg)];

        if (state_reg == hlf_pkg::S_MV_MUL) begin
            case (tap_reg)
                hlf_pkg::TAP_OVER:  mul_w = over_reg;
                hlf_pkg::TAP_EXACT: mul_w = exact_reg;
                hlf_pkg::TAP_UNDER: mul_w = under_reg;
                default:            mul_w = exact_reg;
            endcase
        end else begin
            mul_w = (cell_red == seen_reg) ? hit_reg : miss_reg;
        end
        mul_out = {16'h0000, b_val} * {16'h0000, mul_w};

        sum_new = acc_reg + ACC_W'(prod_reg);

        rnd = acc_reg + ACC_W'(32768);
        move_val = (|rnd[ACC_W-1:32]) ? 16'hFFFF : rnd[31:16];

        div_dividend = DIV_W'({prod_reg, 16'h0000}) + DIV_W'(acc_reg[SUM_W-1:1]);
        div_val = div_quo[hlf_pkg::QUO_W-1] ? 16'hFFFF : div_quo[15:0];

        // shift taken modulo the world size
        u_work = 7'(s_tdata[4:1]);
        for (int k = 0; k < 8; k++) begin
            if (u_work >= 7'(CELLS)) begin
                u_work = u_work - 7'(CELLS);
            end
        end
        u_in = IW'(u_work);

        // source cell of a tap: i - u - 1 + tap, kept in [CELLS, 3*CELLS] then folded
        tap_x = TW'(idx_reg) + TW'(2 * CELLS - 1) - TW'(u_reg) + TW'(tap_reg);
        tap_y = tap_x - TW'(CELLS);
        if (tap_y >= TW'(CELLS)) begin
            tap_y = tap_y - TW'(CELLS);
        end
        if (tap_y >= TW'(CELLS)) begin
            tap_y = tap_y - TW'(CELLS);
        end
        tap_addr = tap_y[IW-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hlf_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == hlf_pkg::OP_MOVE) ? hlf_pkg::S_MV_RD
                                                               : hlf_pkg::S_SUM_RD;
                end
            end
            hlf_pkg::S_SUM_RD:  state_next = hlf_pkg::S_SUM_MUL;
            hlf_pkg::S_SUM_MUL: state_next = hlf_pkg::S_SUM_ACC;
            hlf_pkg::S_SUM_ACC: begin
                if (!idx_last) begin
                    state_next = hlf_pkg::S_SUM_RD;
                end else if (sum_new == '0) begin
                    state_next = hlf_pkg::S_OUT_RD;
                end else begin
                    state_next = hlf_pkg::S_DIV_RD;
                end
            end
            hlf_pkg::S_DIV_RD:    state_next = hlf_pkg::S_DIV_MUL;
            hlf_pkg::S_DIV_MUL:   state_next = hlf_pkg::S_DIV_START;
            hlf_pkg::S_DIV_START: state_next = hlf_pkg::S_DIV_RUN;
            hlf_pkg::S_DIV_RUN: begin
                if (div_done) begin
                    state_next = idx_last ? hlf_pkg::S_OUT_RD : hlf_pkg::S_DIV_RD;
                end
            end
            hlf_pkg::S_MV_RD:  state_next = hlf_pkg::S_MV_MUL;
            hlf_pkg::S_MV_MUL: state_next = hlf_pkg::S_MV_ACC;
            hlf_pkg::S_MV_ACC: begin
                state_next = (tap_reg == hlf_pkg::TAP_UNDER) ? hlf_pkg::S_MV_WR
                                                             : hlf_pkg::S_MV_RD;
            end
            hlf_pkg::S_MV_WR: begin
                state_next = idx_last ? hlf_pkg::S_OUT_RD : hlf_pkg::S_MV_RD;
            end
            hlf_pkg::S_OUT_RD: state_next = hlf_pkg::S_OUT_LD;
            hlf_pkg::S_OUT_LD: state_next = hlf_pkg::S_OUT_WAIT;
            hlf_pkg::S_OUT_WAIT: begin
                if (m_tready) begin
                    state_next = idx_last ? hlf_pkg::S_IDLE : hlf_pkg::S_OUT_RD;
                end
            end
            default: state_next = hlf_pkg::S_IDLE;
        endcase
    end

    // handshake and read address
    always_comb begin
        s_tready = state_reg == hlf_pkg::S_IDLE;
        m_tvalid = state_reg == hlf_pkg::S_OUT_WAIT;
        rd_addr  = (state_reg == hlf_pkg::S_MV_RD) ? tap_addr : idx_reg;
    end

    // datapath
    always_comb begin
        seen_next     = seen_reg;
        u_next        = u_reg;
        idx_next      = idx_reg;
        tap_next      = tap_reg;
        bank_next     = bank_reg;
        valid_next    = valid_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        zero_next     = zero_reg;
        out_idx_next  = out_idx_reg;
        out_prob_next = out_prob_reg;
        out_zero_next = out_zero_reg;
        out_last_next = out_last_reg;
        mem_we        = 1'b0;
        mem_waddr     = {bank_reg, idx_reg};
        mem_wdata     = div_val;
        div_start     = 1'b0;

        case (state_reg)
            hlf_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    seen_next = s_tdata[0];
                    u_next    = u_in;
                    idx_next  = '0;
                    tap_next  = hlf_pkg::TAP_OVER;
                    acc_next  = '0;
                    zero_next = 1'b0;
                end
            end
            hlf_pkg::S_SUM_MUL, hlf_pkg::S_DIV_MUL, hlf_pkg::S_MV_MUL: begin
                prod_next = mul_out;
            end
            hlf_pkg::S_SUM_ACC: begin
                acc_next = sum_new;
                if (idx_last) begin
                    zero_next = sum_new == '0;
                    idx_next  = '0;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            hlf_pkg::S_DIV_START: begin
                div_start = 1'b1;
            end
            hlf_pkg::S_DIV_RUN: begin
                if (div_done) begin
                    mem_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    idx_next = idx_last ? '0 : idx_reg + IW'(1);
                end
            end
            hlf_pkg::S_MV_ACC: begin
                acc_next = sum_new;
                tap_next = (tap_reg == hlf_pkg::TAP_UNDER) ? hlf_pkg::TAP_OVER
                                                           : tap_reg + 2'd1;
            end
            hlf_pkg::S_MV_WR: begin
                // new belief goes to the other bank, old one stays readable
                mem_we    = 1'b1;
                mem_waddr = {~bank_reg, idx_reg};
                mem_wdata = move_val;
                acc_next  = '0;
                if (idx_last) begin
                    bank_next  = ~bank_reg;
                    valid_next = '1;
                    idx_next   = '0;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            hlf_pkg::S_OUT_LD: begin
                out_idx_next  = 4'(idx_reg);
                out_prob_next = b_val;
                out_zero_next = zero_reg;
                out_last_next = idx_last;
            end
            hlf_pkg::S_OUT_WAIT: begin
                if (m_tready) begin
                    idx_next = idx_last ? '0 : idx_reg + IW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hlf_pkg::S_IDLE;
            bank_reg  <= 1'b0;
            valid_reg <= '0;
            idx_reg   <= '0;
            tap_reg   <= hlf_pkg::TAP_OVER;
        end else begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            tap_reg   <= tap_next;
        end
    end

    always_ff @(posedge aclk) begin
        seen_reg     <= seen_next;
        u_reg        <= u_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        zero_reg     <= zero_next;
        out_idx_reg  <= out_idx_next;
        out_prob_reg <= out_prob_next;
        out_zero_reg <= out_zero_next;
        out_last_reg <= out_last_next;
    end

    // belief store, two banks selected by bank_reg
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            belief_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg  <= belief_mem[{bank_reg, rd_addr}];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    hlf_divider #(
        .SUM_W(SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (acc_reg[SUM_W-1:0]),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign m_tdata = {4'h0, out_prob_reg, out_idx_reg};
    assign m_tuser = out_zero_reg;
    assign m_tlast = out_last_reg;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_last_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[3:0] == 4'(CELLS - 1))
        else $error("tlast on a cell other than the final one");

    a_move_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == hlf_pkg::S_MV_WR && idx_last |=> &valid_reg)
        else $error("belief not fully valid after a move");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == hlf_pkg::S_DIV_RUN)
        else $error("divider result outside the normalize step");

endmodule
